[sv/spc_pkg.sv]
// Shared types and constants for the saturating PI controller.
package spc_pkg;

    localparam int GAIN_W      = 8;
    localparam int SHIFT_W     = 5;
    localparam int LIMIT_W     = 30;
    localparam int ERR_W       = 32;
    localparam int ACC_W       = 63;
    localparam int ACC_LIMIT_W = 62;
    localparam int DIVIDEND_W  = LIMIT_W + (1 << SHIFT_W) - 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [GAIN_W-1:0]      PROP_GAIN_RESET   = 8'd1;
    localparam logic [GAIN_W-1:0]      INTEG_GAIN_RESET  = 8'd1;
    localparam logic [SHIFT_W-1:0]     INTEG_SHIFT_RESET = 5'd0;
    localparam logic [SHIFT_W-1:0]     ERROR_SHIFT_RESET = 5'd0;
    localparam logic [LIMIT_W-1:0]     LIMIT_RESET       = 30'h3FFF_FFFF;
    localparam logic [ACC_LIMIT_W-1:0] ACC_LIMIT_RESET   = 62'h3FFF_FFFF;
    localparam logic [ACC_LIMIT_W-1:0] ACC_LIMIT_ZERO_GAIN = {ACC_LIMIT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_INTEG_SHIFT = 3'd2,
        REG_ERROR_SHIFT = 3'd3,
        REG_PROP_LIMIT  = 3'd4,
        REG_INTEG_LIMIT = 3'd5
    } spc_reg_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [GAIN_W-1:0]     divisor;
    } spc_div_req_t;

endpackage

[sv/saturating_pi_controller.sv]
// Saturating PI controller: four-stage pipeline with anti-windup accumulator clamp.
// One request can be accepted per cycle while in_stall is low.
// A configuration write to registers 0 to 5 starts a bit-serial division of the accumulator
// limit (with zero integral gain the limit is set to all ones instead); requests and writes are held off meanwhile.
// Reset restores the register defaults, clears the accumulator and empties the pipeline.
module saturating_pi_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               enable,
    input  logic signed [spc_pkg::ERR_W-1:0]   error_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 drive,
    output logic signed [30:0]                 prop_term,
    output logic signed [30:0]                 integ_term
);
    import spc_pkg::*;

    logic [GAIN_W-1:0]      prop_gain_reg;
    logic [GAIN_W-1:0]      integ_gain_reg;
    logic [SHIFT_W-1:0]     integ_shift_reg;
    logic [SHIFT_W-1:0]     error_shift_reg;
    logic [LIMIT_W-1:0]     prop_limit_reg;
    logic [LIMIT_W-1:0]     integ_limit_reg;
    logic                   cfg_pending_reg;
    logic                   cfg_write;

    spc_div_req_t           div_req;
    logic                   div_busy;
    logic [ACC_LIMIT_W-1:0] acc_limit;

    logic                   s1_v_reg;
    logic                   s1_en_reg;
    logic signed [ERR_W-1:0] s1_err_reg;
    logic                   s2_v_reg;
    logic                   s2_en_reg;
    logic signed [ERR_W-1:0] s2_err_reg;
    logic signed [ACC_W-1:0] s2_sum_reg;
    logic                   s3_v_reg;
    logic signed [40:0]     s3_pprod_reg;
    logic signed [63:0]     s3_iprod_reg;
    logic                   s4_v_reg;
    logic signed [31:0]     drive_reg;
    logic signed [30:0]     prop_term_reg;
    logic signed [30:0]     integ_term_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic                   s1_rdy;
    logic                   s2_rdy;
    logic                   s3_rdy;
    logic                   s4_rdy;
    logic                   in_take;

    logic signed [ERR_W-1:0] err_sh;
    logic signed [63:0]     acc_wide;
    logic signed [63:0]     lim_wide;
    logic signed [63:0]     sum_wide;
    logic signed [63:0]     sum_cl;
    logic signed [40:0]     pprod;
    logic signed [63:0]     iprod;
    logic signed [40:0]     plim;
    logic signed [40:0]     pcl;
    logic signed [63:0]     ilim;
    logic signed [63:0]     ishift;
    logic signed [63:0]     icl;
    logic signed [31:0]     term_sum;

    // Configuration registers; every accepted write to registers 0 to 5 triggers a limit update.
    assign cfg_ready = !(cfg_pending_reg || div_busy);
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RESET;
            integ_gain_reg  <= INTEG_GAIN_RESET;
            integ_shift_reg <= INTEG_SHIFT_RESET;
            error_shift_reg <= ERROR_SHIFT_RESET;
            prop_limit_reg  <= LIMIT_RESET;
            integ_limit_reg <= LIMIT_RESET;
            cfg_pending_reg <= 1'b0;
        end
        else
        begin
            cfg_pending_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_SHIFT: integ_shift_reg <= cfg_data[SHIFT_W-1:0];
                    REG_ERROR_SHIFT: error_shift_reg <= cfg_data[SHIFT_W-1:0];
                    REG_PROP_LIMIT:  prop_limit_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
                if (cfg_index <= REG_INTEG_LIMIT)
                begin
                    cfg_pending_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        div_req.start    = cfg_pending_reg;
        div_req.dividend = DIVIDEND_W'(integ_limit_reg) << integ_shift_reg;
        div_req.divisor  = integ_gain_reg;
    end

    spc_limit_div u_limit_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .limit (acc_limit)
    );

    // Pipeline flow control.
    assign s4_rdy   = !s4_v_reg || !out_stall;
    assign s3_rdy   = !s3_v_reg || s4_rdy;
    assign s2_rdy   = !s2_v_reg || s3_rdy;
    assign s1_rdy   = !s1_v_reg || s2_rdy;
    assign in_stall = !s1_rdy || cfg_pending_reg || div_busy;
    assign in_take  = in_valid && !in_stall;

    // Stage 1 to 2: scale the error and update the clamped accumulator.
    always_comb
    begin
        err_sh   = s1_err_reg >>> error_shift_reg;
        acc_wide = 64'(acc_reg);
        lim_wide = $signed({2'b00, acc_limit});
        sum_wide = acc_wide + 64'(err_sh);
        if (sum_wide >= lim_wide)
        begin
            sum_cl = lim_wide;
        end
        else if (sum_wide <= -lim_wide)
        begin
            sum_cl = -lim_wide;
        end
        else
        begin
            sum_cl = sum_wide;
        end
        acc_next = s1_en_reg ? sum_cl[ACC_W-1:0] : '0;
    end

    // Stage 2 to 3: the two gain multiplies.
    always_comb
    begin
        pprod = $signed({{9{s2_err_reg[ERR_W-1]}}, s2_err_reg})
              * $signed({33'b0, prop_gain_reg});
        iprod = $signed({s2_sum_reg[ACC_W-1], s2_sum_reg})
              * $signed({56'b0, integ_gain_reg});
    end

    // Stage 3 to 4: shift, clamp and form the drive.
    always_comb
    begin
        plim   = $signed({11'b0, prop_limit_reg});
        ilim   = $signed({34'b0, integ_limit_reg});
        ishift = s3_iprod_reg >>> integ_shift_reg;
        if (s3_pprod_reg > plim)
        begin
            pcl = plim;
        end
        else if (s3_pprod_reg < -plim)
        begin
            pcl = -plim;
        end
        else
        begin
            pcl = s3_pprod_reg;
        end
        if (ishift > ilim)
        begin
            icl = ilim;
        end
        else if (ishift < -ilim)
        begin
            icl = -ilim;
        end
        else
        begin
            icl = ishift;
        end
        term_sum = $signed({pcl[30], pcl[30:0]}) + $signed({icl[30], icl[30:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_v_reg <= in_take;
            end
            if (s2_rdy)
            begin
                s2_v_reg <= s1_v_reg;
                if (s1_v_reg)
                begin
                    acc_reg <= acc_next;
                end
            end
            if (s3_rdy)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_rdy)
            begin
                s4_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_en_reg  <= enable;
            s1_err_reg <= error_in;
        end
        if (s2_rdy && s1_v_reg)
        begin
            s2_en_reg  <= s1_en_reg;
            s2_err_reg <= s1_en_reg ? err_sh : '0;
            s2_sum_reg <= acc_next;
        end
        if (s3_rdy && s2_v_reg)
        begin
            s3_pprod_reg <= pprod;
            s3_iprod_reg <= iprod;
        end
        if (s4_rdy && s3_v_reg)
        begin
            prop_term_reg  <= pcl[30:0];
            integ_term_reg <= icl[30:0];
            drive_reg      <= -term_sum;
        end
    end

    assign out_valid  = s4_v_reg;
    assign drive      = drive_reg;
    assign prop_term  = prop_term_reg;
    assign integ_term = integ_term_reg;

    a_acc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_en_reg) |-> (acc_wide <= lim_wide) && (acc_wide >= -lim_wide))
        else $error("accumulator outside its limit");

    a_prop_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        s4_v_reg |-> ($signed(prop_term_reg) <= $signed({1'b0, prop_limit_reg}))
                  && ($signed(prop_term_reg) >= -$signed({1'b0, prop_limit_reg})))
        else $error("proportional term outside its limit");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index <= REG_INTEG_LIMIT)) |=> in_stall)
        else $error("request accepted while the limit is being updated");

endmodule

[sv/spc_limit_div.sv]
// Bit-serial divider that derives the accumulator limit from the configuration.
module spc_limit_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spc_pkg::spc_div_req_t               req,
    output logic                                busy,
    output logic [spc_pkg::ACC_LIMIT_W-1:0]     limit
);
    import spc_pkg::*;

    localparam logic [5:0] DIV_STEPS = 6'(DIVIDEND_W);

    logic                      busy_reg;
    logic [5:0]                count_reg;
    logic [ACC_LIMIT_W-1:0]    limit_reg;
    logic [DIVIDEND_W-1:0]     dvd_reg;
    logic [DIVIDEND_W-1:0]     dvd_next;
    logic [GAIN_W-1:0]         rem_reg;
    logic [GAIN_W-1:0]         rem_next;
    logic [GAIN_W-1:0]         dsr_reg;
    logic [GAIN_W:0]           rem_shift;
    logic                      q_bit;

    // One restoring step: bring down the next dividend bit and try a subtraction.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        q_bit     = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = q_bit ? GAIN_W'(rem_shift - {1'b0, dsr_reg}) : rem_shift[GAIN_W-1:0];
        dvd_next  = {dvd_reg[DIVIDEND_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            limit_reg <= ACC_LIMIT_RESET;
        end
        else if (req.start)
        begin
            if (req.divisor == '0)
            begin
                limit_reg <= ACC_LIMIT_ZERO_GAIN;
            end
            else
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_STEPS;
            end
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_reg  <= 1'b0;
                limit_reg <= {1'b0, dvd_next};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy  = busy_reg;
    assign limit = limit_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the saturating PI controller with anti-windup clamp.
module testbench;
    import spc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 12;
    localparam int PHASE_SAMPLES  = 50;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

    typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_SETTLE} op_kind_t;

    typedef struct {
        op_kind_t                kind;
        logic                    en;
        logic signed [ERR_W-1:0] err;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } op_t;

    typedef struct packed {
        logic [31:0] drive;
        logic [30:0] prop;
        logic [30:0] integ;
    } ctrl_out_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          enable = 1'b0;
    logic signed [ERR_W-1:0]       error_in = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [31:0]            drive;
    logic signed [30:0]            prop_term;
    logic signed [30:0]            integ_term;

    // Controller state as the testbench sees it.
    logic [GAIN_W-1:0]      kp = PROP_GAIN_RESET;
    logic [GAIN_W-1:0]      ki = INTEG_GAIN_RESET;
    logic [SHIFT_W-1:0]     ki_shift = INTEG_SHIFT_RESET;
    logic [SHIFT_W-1:0]     err_shift = ERROR_SHIFT_RESET;
    logic [LIMIT_W-1:0]     kp_clamp = LIMIT_RESET;
    logic [LIMIT_W-1:0]     ki_clamp = LIMIT_RESET;
    longint                 err_sum = 0;
    logic [ACC_LIMIT_W-1:0] err_sum_bound = ACC_LIMIT_RESET;

    op_t       pending[$];
    ctrl_out_t results_due[$];

    bit sample_taken = 0;
    bit write_taken = 0;
    bit result_taken = 0;
    bit sending = 0;
    bit writing = 0;
    bit sink_hold = 0;
    int gap_left = 0;
    int burst_left = 0;
    int sink_left = 0;
    int stuck_cycles = 0;
    int result_count = 0;
    int mismatch_count = 0;

    saturating_pi_controller i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .enable     (enable),
        .error_in   (error_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .prop_term  (prop_term),
        .integ_term (integ_term)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void update_sum_bound();
        if (ki == 0)
        begin
            err_sum_bound = ACC_LIMIT_ZERO_GAIN;
        end
        else
        begin
            err_sum_bound = ACC_LIMIT_W'(({34'b0, ki_clamp} << ki_shift) / ki);
        end
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PROP_GAIN:   kp = data[GAIN_W-1:0];
            REG_INTEG_GAIN:  ki = data[GAIN_W-1:0];
            REG_INTEG_SHIFT: ki_shift = data[SHIFT_W-1:0];
            REG_ERROR_SHIFT: err_shift = data[SHIFT_W-1:0];
            REG_PROP_LIMIT:  kp_clamp = data[LIMIT_W-1:0];
            REG_INTEG_LIMIT: ki_clamp = data[LIMIT_W-1:0];
            default:         return;
        endcase
        update_sum_bound();
    endfunction

    function automatic longint clamp_mag(longint v, longint m);
        if (v > m)
        begin
            return m;
        end
        if (v < -m)
        begin
            return -m;
        end
        return v;
    endfunction

    function automatic ctrl_out_t predict_drive(logic en, logic signed [ERR_W-1:0] sample);
        longint    err;
        longint    bound;
        longint    p;
        longint    i;
        longint    d;
        ctrl_out_t res;
        if (!en)
        begin
            err_sum = 0;
            return '0;
        end
        err = longint'(sample) >>> err_shift;
        bound = longint'(err_sum_bound);
        err_sum = err_sum + err;
        if (err_sum >= bound)
        begin
            err_sum = bound;
        end
        else if (err_sum <= -bound)
        begin
            err_sum = -bound;
        end
        p = clamp_mag(longint'(kp) * err, longint'(kp_clamp));
        i = clamp_mag((err_sum * longint'(ki)) >>> ki_shift, longint'(ki_clamp));
        d = -(p + i);
        res.drive = d[31:0];
        res.prop = p[30:0];
        res.integ = i[30:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            burst_left = 40;
            return 0;
        end
        return pick_len();
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int                    r;
        v = $urandom;
        r = $urandom_range(0, 3);
        case (idx)
            REG_PROP_GAIN, REG_INTEG_GAIN:
            begin
                if (r == 0) v[GAIN_W-1:0] = '0;
                else if (r == 1) v[GAIN_W-1:0] = '1;
                else if (r == 2) v[GAIN_W-1:0] = GAIN_W'($urandom_range(1, 4));
            end
            REG_INTEG_SHIFT, REG_ERROR_SHIFT:
            begin
                if (r == 0) v[SHIFT_W-1:0] = '0;
                else if (r == 1) v[SHIFT_W-1:0] = '1;
                else if (r == 2) v[SHIFT_W-1:0] = SHIFT_W'($urandom_range(0, 8));
            end
            REG_PROP_LIMIT, REG_INTEG_LIMIT:
            begin
                if (r == 0) v[LIMIT_W-1:0] = '0;
                else if (r == 1) v[LIMIT_W-1:0] = '1;
                else if (r == 2) v[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 100000));
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return $urandom;
        end
        if (r < 85)
        begin
            return $urandom_range(0, 2000) - 1000;
        end
        if (r < 90)
        begin
            return ERR_MAX;
        end
        if (r < 95)
        begin
            return ERR_MIN;
        end
        return (r < 98) ? 32'sd0 : -32'sd1;
    endfunction

    task automatic add_sample(logic en, logic signed [ERR_W-1:0] err);
        op_t op;
        op.kind = OP_SAMPLE;
        op.en = en;
        op.err = err;
        op.idx = '0;
        op.data = '0;
        pending.push_back(op);
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        op_t op;
        op.kind = OP_WRITE;
        op.en = 1'b0;
        op.err = '0;
        op.idx = idx;
        op.data = data;
        pending.push_back(op);
    endtask

    task automatic add_settle();
        op_t op;
        op.kind = OP_SETTLE;
        op.en = 1'b0;
        op.err = '0;
        op.idx = '0;
        op.data = '0;
        pending.push_back(op);
    endtask

    // Request driver and result sink, both updated on the falling edge.
    always @(negedge clk)
    begin : driver
        op_t head;
        if (rst_n)
        begin
            if (sample_taken)
            begin
                sending = 0;
            end
            if (write_taken)
            begin
                writing = 0;
            end
            if (!sending && !writing)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending.size() > 0)
                begin
                    head = pending[0];
                    case (head.kind)
                        OP_SAMPLE:
                        begin
                            void'(pending.pop_front());
                            enable <= head.en;
                            error_in <= head.err;
                            sending = 1;
                            gap_left = next_gap();
                        end
                        OP_WRITE:
                        begin
                            if (results_due.size() == 0)
                            begin
                                void'(pending.pop_front());
                                cfg_index <= head.idx;
                                cfg_data <= head.data;
                                writing = 1;
                            end
                        end
                        default:
                        begin
                            if (results_due.size() == 0)
                            begin
                                void'(pending.pop_front());
                            end
                        end
                    endcase
                end
            end
            in_valid <= sending;
            cfg_valid <= writing;

            if (sink_left == 0)
            begin
                if (sink_hold)
                begin
                    sink_hold = 0;
                    sink_left = ($urandom_range(0, 19) == 0) ? 80 : $urandom_range(1, 6);
                end
                else
                begin
                    sink_hold = 1;
                    sink_left = 1 + pick_len();
                end
            end
            sink_left--;
            out_stall <= sink_hold;
        end
    end

    // Handshake monitor, prediction, checking and watchdog on the rising edge.
    always @(posedge clk)
    begin : monitor
        ctrl_out_t want;
        if (rst_n)
        begin
            sample_taken = in_valid && !in_stall;
            write_taken = cfg_valid && cfg_ready;
            result_taken = out_valid && !out_stall;
            if (write_taken)
            begin
                write_register(cfg_index, cfg_data);
            end
            if (result_taken)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = results_due.pop_front();
                    if (drive !== want.drive)
                    begin
                        report_mismatch($sformatf("drive got %h expected %h",
                                                  drive, want.drive));
                    end
                    if (prop_term !== want.prop)
                    begin
                        report_mismatch($sformatf("prop_term got %h expected %h",
                                                  prop_term, want.prop));
                    end
                    if (integ_term !== want.integ)
                    begin
                        report_mismatch($sformatf("integ_term got %h expected %h",
                                                  integ_term, want.integ));
                    end
                end
                result_count++;
            end
            if (sample_taken)
            begin
                results_due.push_back(predict_drive(enable, error_in));
            end
            if (sample_taken || write_taken || result_taken)
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Timeout: no handshake for %0d cycles", stuck_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_IDX_W-1:0] idx;
        int                   writes;

        // Reset configuration, accumulator saturation in both directions and disable.
        add_sample(1'b1, 32'sd0);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b0, ERR_MAX);
        add_sample(1'b1, -32'sd1);
        add_sample(1'b1, 32'sd1);
        add_sample(1'b0, 32'sd0);

        // Zero integral gain lets the accumulator grow far past the later bound.
        add_write(REG_INTEG_GAIN, 32'hABCD_EF00);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MAX);

        // The stale accumulator must be clamped on the next enabled step.
        add_write(REG_INTEG_GAIN, 32'hFFFF_FF01);
        add_sample(1'b1, 32'sd0);
        add_sample(1'b1, ERR_MIN);

        add_write(REG_PROP_GAIN, 32'h0000_00FF);
        add_write(REG_INTEG_GAIN, 32'h0000_00FF);
        add_write(REG_INTEG_SHIFT, 32'hFFFF_FFFF);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b1, 32'sd12345);

        add_write(REG_ERROR_SHIFT, 32'h0000_001F);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b1, ERR_MAX);

        add_write(REG_PROP_LIMIT, 32'hC000_0000);
        add_write(REG_INTEG_LIMIT, 32'h0000_0000);
        add_write(REG_ERROR_SHIFT, 32'h0000_0001);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b1, ERR_MAX);

        add_write(IDX_SPARE_A, $urandom);
        add_write(IDX_SPARE_B, $urandom);
        add_sample(1'b1, -32'sd5);

        add_write(REG_PROP_LIMIT, 32'hFFFF_FFFF);
        add_write(REG_INTEG_LIMIT, 32'h3FFF_FFFF);
        add_write(REG_PROP_GAIN, 32'h0000_0000);
        add_write(REG_INTEG_SHIFT, 32'h0000_0000);
        add_sample(1'b1, ERR_MAX);
        add_sample(1'b1, ERR_MIN);
        add_sample(1'b0, -32'sd1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            writes = $urandom_range(1, 4);
            for (int w = 0; w < writes; w++)
            begin
                idx = CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1));
                add_write(idx, pick_reg_value(idx));
            end
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ($urandom_range(0, 79) == 0)
                begin
                    add_settle();
                end
                add_sample($urandom_range(0, 19) != 0, pick_error());
            end
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || sending || writing)
        begin
            @(posedge clk);
        end
        while (results_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[saturating_pi_controller.f]
sv/spc_pkg.sv
sv/spc_limit_div.sv
sv/saturating_pi_controller.sv
sim/testbench.sv
